// ----- rtl/dhq_pkg.sv -----
// ----------------------------------------------------------------------------
// dhq_pkg
// Shared types and constants for the detector hit qualifier.
// ----------------------------------------------------------------------------
package dhq_pkg;

  // Geometry and timing constants
  localparam int unsigned MAX_STRIPS   = 1024;
  localparam int unsigned NUM_PLANES   = 2;
  localparam int unsigned NS_PER_COUNT = 8;
  localparam int unsigned SUBNS_PER_NS = 16;
  localparam int unsigned WINDOW_TAIL  = 22;
  localparam int unsigned JUNK_PULSE   = 179;

  localparam int unsigned TBL_DEPTH = NUM_PLANES * MAX_STRIPS;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

  // Field widths
  localparam int unsigned PLANE_W  = 2;
  localparam int unsigned STRIP_W  = 11;
  localparam int unsigned QUAL_W   = 2;
  localparam int unsigned PTIME_W  = 11;
  localparam int unsigned AMP_W    = 12;
  localparam int unsigned HEIGHT_W = 19;
  localparam int unsigned HTIME_W  = 21;
  localparam int unsigned BASE_W   = 20;
  localparam int unsigned CUT_W    = 16;
  localparam int unsigned SHIFT_W  = 3;
  localparam int unsigned WWORDS_W = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Plane numbers
  localparam logic [PLANE_W-1:0] PLANE_ONE = PLANE_W'(1);
  localparam logic [PLANE_W-1:0] PLANE_TWO = PLANE_W'(2);

  // Strip quality codes
  localparam logic [QUAL_W-1:0] QUAL_GOOD  = 2'd0;
  localparam logic [QUAL_W-1:0] QUAL_BAD   = 2'd1;
  localparam logic [QUAL_W-1:0] QUAL_NOISY = 2'd2;

  typedef enum logic {
    OP_HIT  = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK_THR   = 3'd0,
    CFG_LOW_CUT    = 3'd1,
    CFG_AMP_SHIFT  = 3'd2,
    CFG_PED_SHIFT  = 3'd3,
    CFG_WIN_WORDS  = 3'd4,
    CFG_BASE_PL1   = 3'd5,
    CFG_BASE_PL2   = 3'd6
  } cfg_idx_e;

endpackage

// ----- rtl/detector_hit_qualifier_core.sv -----
// ----------------------------------------------------------------------------
// detector_hit_qualifier_core
// Strip quality lookup, hit qualification and time calibration.
// ----------------------------------------------------------------------------
// Pipeline: a hit's quality memory read and its fields are registered into the
//   check stage; the check result is then registered into the output register.
// Throughput: one item per cycle while the output is not stalled and no
//   clearing pass is running.
// Reset: registers take their reset values at once; then a clearing pass
//   writes all TBL_DEPTH (2048) quality entries to good, with in_ready_o
//   low. Configuration writes are taken throughout.
module detector_hit_qualifier_core
  import dhq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  // input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [PLANE_W-1:0]    plane_i,
  input  logic [STRIP_W-1:0]    strip_i,
  input  logic [QUAL_W-1:0]     quality_code_i,
  input  logic [PTIME_W-1:0]    pulse_time_i,
  input  logic [PTIME_W-1:0]    peak_time_i,
  input  logic [AMP_W-1:0]      peak_amp_i,
  input  logic [AMP_W-1:0]      raw_pedestal_i,

  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PLANE_W-1:0]    hit_plane_o,
  output logic [STRIP_W-1:0]    hit_strip_o,
  output logic [HEIGHT_W-1:0]   pulse_height_o,
  output logic [HEIGHT_W-1:0]   scaled_pedestal_o,
  output logic signed [HTIME_W-1:0] hit_time_o
);

  // Time arithmetic width: wide enough for window_words * NS_PER_COUNT
  localparam int unsigned TNS_W     = WWORDS_W + $clog2(NS_PER_COUNT) + 1;
  localparam int unsigned TIME_MULT = NS_PER_COUNT * SUBNS_PER_NS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [HEIGHT_W-1:0]      peak_thr_q;
  logic [CUT_W-1:0]         low_cut_q;
  logic [SHIFT_W-1:0]       amp_shift_q;
  logic [SHIFT_W-1:0]       ped_shift_q;
  logic [WWORDS_W-1:0]      win_words_q;
  logic signed [BASE_W-1:0] base_pl1_q;
  logic signed [BASE_W-1:0] base_pl2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_thr_q  <= HEIGHT_W'(100);
      low_cut_q   <= '0;
      amp_shift_q <= SHIFT_W'(3);
      ped_shift_q <= '0;
      win_words_q <= WWORDS_W'(80);
      base_pl1_q  <= '0;
      base_pl2_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PEAK_THR:  peak_thr_q  <= cfg_data_i[HEIGHT_W-1:0];
        CFG_LOW_CUT:   low_cut_q   <= cfg_data_i[CUT_W-1:0];
        CFG_AMP_SHIFT: amp_shift_q <= cfg_data_i[SHIFT_W-1:0];
        CFG_PED_SHIFT: ped_shift_q <= cfg_data_i[SHIFT_W-1:0];
        CFG_WIN_WORDS: win_words_q <= cfg_data_i[WWORDS_W-1:0];
        CFG_BASE_PL1:  base_pl1_q  <= $signed(cfg_data_i[BASE_W-1:0]);
        CFG_BASE_PL2:  base_pl2_q  <= $signed(cfg_data_i[BASE_W-1:0]);
        default: ;  // unmapped index: write is dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic              clr_busy_q;
  logic [TBL_AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + TBL_AW'(1);
      if (clr_addr_q == TBL_AW'(TBL_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: accept, table address, memory access
  // --------------------------------------------------------------------------
  logic              s1_valid_q;
  logic              s1_adv;
  logic              in_xfer;
  logic              idx_ok;
  logic [TBL_AW-1:0] tbl_addr;
  logic [STRIP_W-1:0] strip_m1;

  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Plane must be 1 or 2; strip must be 1..MAX_STRIPS
  assign idx_ok = ((plane_i == PLANE_ONE) || (plane_i == PLANE_TWO))
                  && (strip_i != '0)
                  && ({1'b0, strip_i} <= (STRIP_W + 1)'(MAX_STRIPS));
  assign strip_m1 = strip_i - STRIP_W'(1);
  assign tbl_addr = ((plane_i == PLANE_TWO) ? TBL_AW'(MAX_STRIPS) : '0)
                    + TBL_AW'(strip_m1);

  logic              mem_we;
  logic [TBL_AW-1:0] mem_waddr;
  logic [QUAL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [QUAL_W-1:0] qual_table [TBL_DEPTH];
  logic [QUAL_W-1:0] qual_rd_q;

  // Loads write at transfer; a hit read in the next cycle already sees it.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tbl_addr;
    mem_wdata = quality_code_i;
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = QUAL_GOOD;
    end else if (in_xfer && (op_e'(operation_i) == OP_LOAD) && idx_ok) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = in_xfer && (op_e'(operation_i) == OP_HIT);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      qual_table[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      qual_rd_q <= qual_table[tbl_addr];
    end
  end

  // Stage 1 payload: held while the stage stalls
  logic [PLANE_W-1:0] s1_plane_q;
  logic [STRIP_W-1:0] s1_strip_q;
  logic               s1_idx_ok_q;
  logic               s1_junk_q;
  logic [PTIME_W-1:0] s1_ptime_q;
  logic [AMP_W-1:0]   s1_amp_q;
  logic [AMP_W-1:0]   s1_ped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (mem_re) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_plane_q  <= plane_i;
      s1_strip_q  <= strip_i;
      s1_idx_ok_q <= idx_ok;
      s1_junk_q   <= (pulse_time_i == PTIME_W'(JUNK_PULSE));
      s1_ptime_q  <= peak_time_i;
      s1_amp_q    <= peak_amp_i;
      s1_ped_q    <= raw_pedestal_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: qualification and calibration
  // --------------------------------------------------------------------------
  logic [HEIGHT_W-1:0]   peak_sc;
  logic [HEIGHT_W-1:0]   ped_sc;
  logic [HEIGHT_W:0]     height_diff;   // MSB set means negative
  logic                  height_ok;
  logic [TNS_W-1:0]      t_ns;
  logic [TNS_W-1:0]      t_upper;
  logic                  win_open;
  logic                  time_ok;
  logic                  qual_ok;
  logic                  keep;
  logic signed [HTIME_W-1:0] time_cal;

  assign peak_sc     = HEIGHT_W'(s1_amp_q) << amp_shift_q;
  assign ped_sc      = HEIGHT_W'(s1_ped_q) << ped_shift_q;
  assign height_diff = {1'b0, peak_sc} - {1'b0, ped_sc};
  assign height_ok   = !height_diff[HEIGHT_W]
                       && (height_diff[HEIGHT_W-1:0] >= peak_thr_q);

  // A window shorter than the tail closes it completely
  assign win_open = (win_words_q >= WWORDS_W'(WINDOW_TAIL));
  assign t_ns     = TNS_W'(s1_ptime_q) * TNS_W'(NS_PER_COUNT);
  assign t_upper  = TNS_W'(win_words_q - WWORDS_W'(WINDOW_TAIL))
                    * TNS_W'(NS_PER_COUNT);
  assign time_ok  = win_open && (t_ns >= TNS_W'(low_cut_q)) && (t_ns <= t_upper);

  assign qual_ok = (qual_rd_q != QUAL_BAD) && (qual_rd_q != QUAL_NOISY);
  assign keep    = s1_idx_ok_q && !s1_junk_q && qual_ok && height_ok && time_ok;

  assign time_cal = $signed(HTIME_W'(s1_ptime_q) * HTIME_W'(TIME_MULT))
                    + HTIME_W'((s1_plane_q == PLANE_ONE) ? base_pl1_q : base_pl2_q);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic out_valid_q;

  assign s1_adv = s1_valid_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= keep;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && keep) begin
      hit_plane_o       <= s1_plane_q;
      hit_strip_o       <= s1_strip_q;
      pulse_height_o    <= height_diff[HEIGHT_W-1:0];
      scaled_pedestal_o <= ped_sc;
      hit_time_o        <= time_cal;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // No item is taken while the table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("input taken during clearing pass");

  // A stalled check stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("check stage lost a stalled item");

  // Every result comes from a hit that was in the check stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a checked hit");

  // Results only carry a real plane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((hit_plane_o == PLANE_ONE) || (hit_plane_o == PLANE_TWO)))
    else $error("result with plane out of range");
`endif

endmodule
